@@ rtl/fbm_pkg.sv @@
// shared constants, types and helpers of the fractal value noise texel block
package fbm_pkg;

  localparam int MaxOctaves = 8;
  localparam int PeriodBits = 15;
  localparam int LaneStages = 5;
  localparam int NormStages = 7;

  localparam logic [31:0] HashKx   = 32'd374761393;
  localparam logic [31:0] HashKy   = 32'd668265263;
  localparam logic [31:0] HashKs   = 32'd1440445633;
  localparam logic [31:0] HashMix  = 32'd1274126177;
  localparam logic [31:0] SeedStep = 32'd37;
  localparam logic [23:0] HashMask = 24'hFFFFFF;

  typedef enum logic [3:0] {
    RegSeed    = 4'd0,
    RegOctaves = 4'd1,
    RegScale   = 4'd2,
    RegMode    = 4'd3
  } cfg_reg_e;

  typedef logic [LaneStages-1:0] lane_en_t;
  typedef logic [NormStages-1:0] norm_en_t;

  typedef struct packed {
    logic [3:0] octaves;
    logic       raw_mode;
  } texel_ctl_t;

  // final xor-shift of the hash, low 24 bits only
  function automatic logic [23:0] hash_fold(logic [31:0] g);
    return g[23:0] ^ {8'd0, g[31:16]};
  endfunction

  // ceil(2^40 / (2^n - 1)), exact quotient for sums below 2^32
  function automatic logic [38:0] norm_recip(logic [3:0] n);
    logic [38:0] r;
    case (n)
      4'd2:    r = 39'd366503875926;
      4'd3:    r = 39'd157073089683;
      4'd4:    r = 39'd73300775186;
      4'd5:    r = 39'd35468117026;
      4'd6:    r = 39'd17452565521;
      4'd7:    r = 39'd8657571873;
      4'd8:    r = 39'd4311810306;
      default: r = 39'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/fbm_value_noise_texel.sv @@
// top level of the fractal value noise texel generator
// pipeline: 13 register stages between the accepted beat and the offered result
// throughput: one texel per cycle while the output is not stalled; every octave has its own lane of multipliers
// stalls: each stage holds only while the next one is full, bubbles close up
// reset: valid bits clear, registers return to seed 0, 4 octaves, scale 6554, mode 1
module fbm_value_noise_texel import fbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // texel coordinates in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel_x [7:0], pixel_y [15:8]
  // grey level out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // luminance [7:0]
);

  localparam int Stages = 1 + LaneStages + NormStages;

  // config registers, always ready
  logic [31:0] seed_q;
  logic [3:0]  octaves_q;
  logic [15:0] scale_q;
  logic        mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= 32'd0;
      octaves_q <= 4'd4;
      scale_q   <= 16'd6554;
      mode_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSeed:    seed_q    <= cfg_data_i;
        RegOctaves: octaves_q <= cfg_data_i[3:0];
        RegScale:   scale_q   <= cfg_data_i[15:0];
        RegMode:    mode_q    <= cfg_data_i[0];
        default:    ;  // unknown index, dropped
      endcase
    end
  end

  // valid bits and per-stage advance chain
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[Stages-1];

  // stage 0: coordinates into lattice space, octave count saturated
  logic [7:0]  px_q, py_q;
  logic [23:0] bx_q, by_q;
  logic [31:0] seed0_q;
  texel_ctl_t  ctl_d;
  texel_ctl_t  ctl_q [LaneStages+1];

  always_comb begin
    ctl_d.octaves  = (octaves_q > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octaves_q;
    ctl_d.raw_mode = !mode_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px_q     <= s_axis_tdata[7:0];
      py_q     <= s_axis_tdata[15:8];
      bx_q     <= 24'(s_axis_tdata[7:0]) * 24'(scale_q);
      by_q     <= 24'(s_axis_tdata[15:8]) * 24'(scale_q);
      seed0_q  <= seed_q;
      ctl_q[0] <= ctl_d;
    end
    // control rides alongside the octave lanes
    for (int k = 1; k <= LaneStages; k++) begin
      if (en[k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // octave lanes
  lane_en_t    lane_en;
  logic [23:0] v [MaxOctaves];

  assign lane_en = en[LaneStages:1];

  for (genvar i = 0; i < MaxOctaves; i++) begin : g_lane
    fbm_octave_lane #(
      .Idx (i)
    ) u_lane (
      .clk_i      (clk_i),
      .stage_en_i (lane_en),
      .bx_i       (bx_q),
      .by_i       (by_q),
      .px_i       (px_q),
      .py_i       (py_q),
      .seed_i     (seed0_q),
      .raw_i      (ctl_q[0].raw_mode),
      .v_o        (v[i])
    );
  end

  // octave sum, normalize, smoothstep, byte
  norm_en_t norm_en;

  assign norm_en = en[Stages-1:LaneStages+1];

  fbm_norm u_norm (
    .clk_i      (clk_i),
    .stage_en_i (norm_en),
    .v_i        (v),
    .ctl_i      (ctl_q[LaneStages]),
    .lum_o      (m_axis_tdata)
  );

`ifndef SYNTHESIS
  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // empty pipeline always takes a beat
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> s_axis_tready)
    else $error("pipeline empty but input not ready");

  // accepted beat lands in stage 0
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> vld_q[0])
    else $error("accepted beat lost at stage 0");

  // beats in flight change only by accepts and deliveries
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) == $past($countones(vld_q)) + 32'($past(in_fire))
              - 32'($past(out_fire))))
    else $error("beat count mismatch in pipeline");

  // a stalled result stays in the last stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("stalled result dropped");
`endif

endmodule

@@ rtl/fbm_octave_lane.sv @@
// one octave of value noise: lattice hash, fade weights and bilinear blend
module fbm_octave_lane import fbm_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic        clk_i,
  input  lane_en_t    stage_en_i,
  input  logic [23:0] bx_i,
  input  logic [23:0] by_i,
  input  logic [7:0]  px_i,
  input  logic [7:0]  py_i,
  input  logic [31:0] seed_i,
  input  logic        raw_i,
  output logic [23:0] v_o
);

  localparam logic [31:0] SeedOff = 32'(37 * Idx);

  // stage 1
  logic [31:0] cx, cy;
  logic [PeriodBits-1:0] x0, y0, x1, y1;
  logic [31:0] xa_q, xb_q, ya_q, yb_q, sk_q, ffx_q, ffy_q;
  logic [15:0] fx_q, fy_q;
  logic        raw1_q;

  always_comb begin
    cx = {8'd0, bx_i} << Idx;
    cy = {8'd0, by_i} << Idx;
    x0 = cx[16 +: PeriodBits];
    y0 = cy[16 +: PeriodBits];
    if (Idx == 0 && raw_i) begin
      x0 = PeriodBits'(px_i);
      y0 = PeriodBits'(py_i);
    end
    x1 = x0 + PeriodBits'(1);
    y1 = y0 + PeriodBits'(1);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      xa_q   <= 32'(x0) * HashKx;
      xb_q   <= 32'(x1) * HashKx;
      ya_q   <= 32'(y0) * HashKy;
      yb_q   <= 32'(y1) * HashKy;
      sk_q   <= (seed_i + SeedOff) * HashKs;
      ffx_q  <= 32'(cx[15:0]) * 32'(cx[15:0]);
      ffy_q  <= 32'(cy[15:0]) * 32'(cy[15:0]);
      fx_q   <= cx[15:0];
      fy_q   <= cy[15:0];
      raw1_q <= raw_i;
    end
  end

  // stage 2: corner hash mix and fade
  logic [17:0] tx, ty;
  logic [49:0] fadx, fady;
  logic [31:0] hs [4];
  logic [31:0] hx [4];
  logic [31:0] g_q [4];
  logic [16:0] sx_q, sy_q;
  logic        raw2_q;

  always_comb begin
    tx   = 18'd196608 - {1'b0, fx_q, 1'b0};
    ty   = 18'd196608 - {1'b0, fy_q, 1'b0};
    fadx = 50'(ffx_q) * 50'(tx);
    fady = 50'(ffy_q) * 50'(ty);
    hs[0] = xa_q + ya_q + sk_q;
    hs[1] = xb_q + ya_q + sk_q;
    hs[2] = xa_q + yb_q + sk_q;
    hs[3] = xb_q + yb_q + sk_q;
    // first xor-shift ahead of the mixing multiply
    for (int k = 0; k < 4; k++) begin
      hx[k] = hs[k] ^ (hs[k] >> 13);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      g_q[0] <= hx[0] * HashMix;
      g_q[1] <= hx[1] * HashMix;
      g_q[2] <= hx[2] * HashMix;
      g_q[3] <= hx[3] * HashMix;
      sx_q   <= fadx[48:32];
      sy_q   <= fady[48:32];
      raw2_q <= raw1_q;
    end
  end

  // stage 3: corner values and first-order terms
  logic [23:0] ca, cb, cc, cd;
  logic signed [24:0] dba, dca;
  logic signed [25:0] dd_d;
  logic [23:0] a3_q;
  logic signed [42:0] pb_q, pc_q;
  logic signed [25:0] dd_q;
  logic [33:0] sxy_q;
  logic        raw3_q;

  always_comb begin
    ca   = hash_fold(g_q[0]);
    cb   = hash_fold(g_q[1]);
    cc   = hash_fold(g_q[2]);
    cd   = hash_fold(g_q[3]);
    dba  = $signed({1'b0, cb}) - $signed({1'b0, ca});
    dca  = $signed({1'b0, cc}) - $signed({1'b0, ca});
    dd_d = $signed({2'b0, ca}) - $signed({2'b0, cb}) - $signed({2'b0, cc})
         + $signed({2'b0, cd});
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      a3_q   <= ca;
      pb_q   <= 43'(dba) * 43'($signed({1'b0, sx_q}));
      pc_q   <= 43'(dca) * 43'($signed({1'b0, sy_q}));
      dd_q   <= dd_d;
      sxy_q  <= 34'(sx_q) * 34'(sy_q);
      raw3_q <= raw2_q;
    end
  end

  // stage 4: cross term
  logic [23:0] a4_q;
  logic signed [42:0] pb4_q, pc4_q;
  logic signed [60:0] pd_q;
  logic        raw4_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      a4_q   <= a3_q;
      pb4_q  <= pb_q;
      pc4_q  <= pc_q;
      pd_q   <= 61'(dd_q) * 61'($signed({1'b0, sxy_q}));
      raw4_q <= raw3_q;
    end
  end

  // stage 5: blend sum, negative clamps to zero; lane 0 in raw mode passes the corner value
  logic signed [62:0] acc;
  logic [23:0] v_d, v_q;

  always_comb begin
    acc = $signed({7'd0, a4_q, 32'd0}) + (63'(pb4_q) <<< 16) + (63'(pc4_q) <<< 16)
        + 63'(pd_q);
    v_d = acc[62] ? 24'd0 : acc[55:32];
    if (Idx == 0 && raw4_q) begin
      v_d = a4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

@@ rtl/fbm_norm.sv @@
// octave sum, normalization, output smoothstep and byte scaling
module fbm_norm import fbm_pkg::*; (
  input  logic        clk_i,
  input  norm_en_t    stage_en_i,
  input  logic [23:0] v_i [MaxOctaves],
  input  texel_ctl_t  ctl_i,
  output logic [7:0]  lum_o
);

  localparam int Pairs = MaxOctaves / 2;

  texel_ctl_t  ctl_q [NormStages-1];
  logic [23:0] raw_q [NormStages-1];

  // stage 6: amplitude weights, pairwise sums
  logic [31:0] w [MaxOctaves];
  logic [31:0] ps_q [Pairs];

  always_comb begin
    for (int i = 0; i < MaxOctaves; i++) begin
      if (4'(i) < ctl_i.octaves) begin
        w[i] = {8'd0, v_i[i]} << (ctl_i.octaves - 4'd1 - 4'(i));
      end else begin
        w[i] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      for (int j = 0; j < Pairs; j++) begin
        ps_q[j] <= w[2*j] + w[2*j+1];
      end
      ctl_q[0] <= ctl_i;
      raw_q[0] <= v_i[0];
    end
  end

  // stage 7: full sum
  logic [31:0] num_d, num_q;

  always_comb begin
    num_d = 32'd0;
    for (int j = 0; j < Pairs; j++) begin
      num_d = num_d + ps_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      num_q    <= num_d;
      ctl_q[1] <= ctl_q[0];
      raw_q[1] <= raw_q[0];
    end
  end

  // stage 8: reciprocal partial products
  logic [38:0] rc;
  logic [51:0] plo_q;
  logic [50:0] phi_q;
  logic [31:0] num8_q;

  assign rc = norm_recip(ctl_q[1].octaves);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      plo_q    <= 52'(num_q) * 52'(rc[19:0]);
      phi_q    <= 51'(num_q) * 51'(rc[38:20]);
      num8_q   <= num_q;
      ctl_q[2] <= ctl_q[1];
      raw_q[2] <= raw_q[1];
    end
  end

  // stage 9: quotient, single octave divides by one
  logic [71:0] qs;
  logic [31:0] q;
  logic [23:0] n_d, n_q;

  always_comb begin
    qs = (72'(phi_q) << 20) + 72'(plo_q);
    q  = qs[71:40];
    if (ctl_q[2].octaves == 4'd1) begin
      q = num8_q;
    end
    n_d = (q > {8'd0, HashMask}) ? HashMask : q[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      n_q      <= n_d;
      ctl_q[3] <= ctl_q[2];
      raw_q[3] <= raw_q[2];
    end
  end

  // stage 10: n squared and the smoothstep slope
  logic [47:0] nsq;
  logic [23:0] nn_q;
  logic [25:0] t_q;

  assign nsq = 48'(n_q) * 48'(n_q);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      nn_q     <= nsq[47:24];
      t_q      <= 26'd50331648 - {1'b0, n_q, 1'b0};
      ctl_q[4] <= ctl_q[3];
      raw_q[4] <= raw_q[3];
    end
  end

  // stage 11: smoothstep product
  logic [49:0] mp;
  logic [25:0] m_q;

  assign mp = 50'(nn_q) * 50'(t_q);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      m_q      <= mp[49:24];
      ctl_q[5] <= ctl_q[4];
      raw_q[5] <= raw_q[4];
    end
  end

  // stage 12: byte scaling, raw hash divides by 2^24-1
  logic [33:0] lm;
  logic [31:0] rp;
  logic [32:0] rs;
  logic [7:0]  lum_d, lum_q;

  always_comb begin
    lm = (34'(m_q) << 8) - 34'(m_q);
    rp = (32'(raw_q[5]) << 8) - 32'(raw_q[5]);
    rs = 33'(rp) + 33'(rp[31:24]) + 33'd1;
    if (ctl_q[5].raw_mode) begin
      lum_d = rs[31:24];
    end else if (ctl_q[5].octaves == 4'd0) begin
      lum_d = 8'd0;
    end else if (lm[33:32] != 2'd0) begin
      lum_d = 8'hFF;
    end else begin
      lum_d = lm[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[6]) begin
      lum_q <= lum_d;
    end
  end

  assign lum_o = lum_q;

endmodule
